/* rtl/calibration_record_validator_unit_defines.svh */
// assertion macros for the calibration record validator
// used by the top level; no other dependencies
`ifndef CALIBRATION_RECORD_VALIDATOR_UNIT_DEFINES_SVH
`define CALIBRATION_RECORD_VALIDATOR_UNIT_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define CRV_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("crv assertion failed");

// next-cycle implication
`define CRV_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("crv assertion failed");

`else

`define CRV_ASSERT_IMPLIES(label, ante, cons)

`define CRV_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/crv_pkg.sv */
// types, constants and the byte-wide crc step for the record validator
// no dependencies
package crv_pkg;

   localparam logic [31:0] CRC_SEED   = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
   // "EVCM" stored little-endian: byte k of the magic sits at [8k +: 8]
   localparam logic [31:0] MAGIC_WORD = 32'h4D43_5645;

   // record byte positions fit in this width
   localparam int POS_W = 6;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic REG_SUPPORTED_VERSION = 1'b0;
   localparam logic REG_EXPECTED_LENGTH   = 1'b1;

   typedef enum logic [2:0] {
      ST_OK            = 3'd0,
      ST_TOO_SHORT     = 3'd1,
      ST_NO_MAGIC      = 3'd2,
      ST_NEWER_VERSION = 3'd3,
      ST_BAD_LENGTH    = 3'd4,
      ST_CRC_MISMATCH  = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0]  supported_version;
      logic [15:0] expected_length;
   } cfg_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] vcom_mv;
      logic [7:0]  record_version;
   } result_type;

   // reflected crc-32, one byte, eight bit steps
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

/* rtl/calibration_record_validator_unit.sv */
// a marked last byte passes the input register stage, then its result is held in the result register stage
// throughput: one byte per cycle unless the input stalls; the crc runs as an eight-step unrolled byte update
// a held result stalls input only when the staged byte is a final byte
// reset (synchronous, active high) empties both stages, clears the record state
// and sets supported_version to 1 and expected_length to 2
`include "calibration_record_validator_unit_defines.svh"

module calibration_record_validator_unit import crv_pkg::*; #(
   parameter int RECORD_BYTES = 32,
   parameter int MAGIC_POS    = 0,
   parameter int VERSION_POS  = 4,
   parameter int LENGTH_POS   = 5,
   parameter int VCOM_POS     = 7,
   parameter int CRC_POS      = 28
) (
   input  logic                  clock,
   input  logic                  reset,
   // input byte channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_last_byte,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_status,
   output logic [15:0]           rsp_vcom_mv,
   output logic [7:0]            rsp_record_version,
   // configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type    cfg;
   result_type result;

   // input register stage
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;
   logic       s1_load;
   logic       s1_advance;

   // result register stage
   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff;
   logic [15:0] rsp_vcom_ff;
   logic [7:0]  rsp_version_ff;
   logic       rsp_fire;
   logic       rsp_new;

   crv_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // a byte that is not final never needs the result register, so it
   // always moves on; a final byte waits until the result slot frees up
   assign rsp_fire   = rsp_valid_ff && !rsp_stall;
   assign s1_advance = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign s1_load    = req_valid && !req_stall;
   assign rsp_new    = s1_advance && s1_last_ff;

   always_comb begin
      if (s1_load) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_valid_in = rsp_new || (rsp_valid_ff && !rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_byte_ff <= req_data_byte;
         s1_last_ff <= req_last_byte;
      end
      if (rsp_new) begin
         rsp_status_ff  <= result.status;
         rsp_vcom_ff    <= result.vcom_mv;
         rsp_version_ff <= result.record_version;
      end
   end

   // record state advances with each byte leaving the input stage
   crv_parser #(
      .RECORD_BYTES (RECORD_BYTES),
      .MAGIC_POS    (MAGIC_POS),
      .VERSION_POS  (VERSION_POS),
      .LENGTH_POS   (LENGTH_POS),
      .VCOM_POS     (VCOM_POS),
      .CRC_POS      (CRC_POS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (s1_advance),
      .data_byte (s1_byte_ff),
      .last_byte (s1_last_ff),
      .cfg       (cfg),
      .result    (result)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_vcom_mv        = rsp_vcom_ff;
   assign rsp_record_version = rsp_version_ff;

   // input only backs up behind a final byte
   `CRV_ASSERT_IMPLIES(a_stall_only_on_last, req_stall, s1_valid_ff && s1_last_ff)
   // a passing record always carries a nonzero vcom
   `CRV_ASSERT_IMPLIES(a_ok_has_vcom, rsp_valid_ff && (rsp_status_ff == ST_OK), rsp_vcom_ff != 16'd0)
   // a failing record reports zero vcom and version
   `CRV_ASSERT_IMPLIES(a_fail_zero_fields, rsp_valid_ff && (rsp_status_ff != ST_OK), (rsp_vcom_ff == 16'd0) && (rsp_version_ff == 8'd0))
   // a byte that is not final creates no result
   `CRV_ASSERT_NEXT(a_no_result_mid_record, s1_valid_ff && !s1_last_ff && !rsp_valid_ff, !rsp_valid_ff)

endmodule

/* rtl/crv_csr.sv */
// apb register file: supported version and expected length
// depends on crv_pkg
module crv_csr import crv_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [7:0]  version_ff;
   logic [15:0] length_ff;
   logic        reg_idx;
   logic        wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1];
   assign wr_en   = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= 8'd1;
         length_ff  <= 16'd2;
      end else if (wr_en) begin
         case (reg_idx)
            REG_SUPPORTED_VERSION: version_ff <= pwdata[7:0];
            REG_EXPECTED_LENGTH:   length_ff  <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_SUPPORTED_VERSION: prdata = {24'd0, version_ff};
         REG_EXPECTED_LENGTH:   prdata = {16'd0, length_ff};
         default:               prdata = '0;
      endcase
   end

   assign cfg.supported_version = version_ff;
   assign cfg.expected_length   = length_ff;

endmodule

/* rtl/crv_parser.sv */
// record state: crc, magic check, field capture and final status
// depends on crv_pkg
module crv_parser import crv_pkg::*; #(
   parameter int RECORD_BYTES = 32,
   parameter int MAGIC_POS    = 0,
   parameter int VERSION_POS  = 4,
   parameter int LENGTH_POS   = 5,
   parameter int VCOM_POS     = 7,
   parameter int CRC_POS      = 28
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   input  cfg_type    cfg,
   output result_type result
);

   localparam int IDX_W = $clog2(RECORD_BYTES + 1);

   logic [IDX_W-1:0] byte_idx_ff, byte_idx_in;
   logic [31:0]      crc_ff, crc_in;
   logic             magic_ok_ff, magic_ok_in;
   logic [7:0]       version_ff, version_in;
   logic [15:0]      length_ff, length_in;
   logic [15:0]      vcom_ff, vcom_in;
   logic [31:0]      stored_crc_ff, stored_crc_in;
   logic             in_rec;
   logic [POS_W-1:0] idx_x;
   status_type       status;

   always_comb begin
      in_rec        = byte_idx_ff < IDX_W'(RECORD_BYTES);
      idx_x         = POS_W'(byte_idx_ff);
      byte_idx_in   = byte_idx_ff;
      crc_in        = crc_ff;
      magic_ok_in   = magic_ok_ff;
      version_in    = version_ff;
      length_in     = length_ff;
      vcom_in       = vcom_ff;
      stored_crc_in = stored_crc_ff;
      if (in_rec) begin
         if (idx_x < POS_W'(CRC_POS)) begin
            crc_in = crc_byte(crc_ff, data_byte);
         end
         for (int k = 0; k < 4; k++) begin
            if (idx_x == POS_W'(MAGIC_POS + k) && data_byte != MAGIC_WORD[8*k +: 8]) begin
               magic_ok_in = 1'b0;
            end
            if (idx_x == POS_W'(CRC_POS + k)) begin
               stored_crc_in[8*k +: 8] = data_byte;
            end
         end
         for (int k = 0; k < 2; k++) begin
            if (idx_x == POS_W'(LENGTH_POS + k)) begin
               length_in[8*k +: 8] = data_byte;
            end
            if (idx_x == POS_W'(VCOM_POS + k)) begin
               vcom_in[8*k +: 8] = data_byte;
            end
         end
         if (idx_x == POS_W'(VERSION_POS)) begin
            version_in = data_byte;
         end
         byte_idx_in = byte_idx_ff + 1'b1;
      end

      // checks in priority order: too short, magic, version, length, crc, then a zero vcom, reported as bad length
      if (byte_idx_in < IDX_W'(RECORD_BYTES)) begin
         status = ST_TOO_SHORT;
      end else if (!magic_ok_in) begin
         status = ST_NO_MAGIC;
      end else if (version_in > cfg.supported_version) begin
         status = ST_NEWER_VERSION;
      end else if (length_in != cfg.expected_length) begin
         status = ST_BAD_LENGTH;
      end else if (stored_crc_in != (crc_in ^ CRC_SEED)) begin
         status = ST_CRC_MISMATCH;
      end else if (vcom_in == 16'd0) begin
         status = ST_BAD_LENGTH;
      end else begin
         status = ST_OK;
      end

      result.status         = status;
      result.vcom_mv        = (status == ST_OK) ? vcom_in : 16'd0;
      result.record_version = (status == ST_OK) ? version_in : 8'd0;
   end

   // the final byte of a record returns the state to its cleared form
   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         byte_idx_ff   <= '0;
         crc_ff        <= CRC_SEED;
         magic_ok_ff   <= 1'b1;
         version_ff    <= '0;
         length_ff     <= '0;
         vcom_ff       <= '0;
         stored_crc_ff <= '0;
      end else if (step) begin
         byte_idx_ff   <= byte_idx_in;
         crc_ff        <= crc_in;
         magic_ok_ff   <= magic_ok_in;
         version_ff    <= version_in;
         length_ff     <= length_in;
         vcom_ff       <= vcom_in;
         stored_crc_ff <= stored_crc_in;
      end
   end

endmodule
